// ===== src/odce_pkg.sv =====
// Shared constants, opcodes and helpers for the OLED draw-command engine.
package odce_pkg;

  localparam int unsigned DefWidth  = 96;
  localparam int unsigned DefHeight = 64;
  localparam int unsigned NumParams = 10;

  localparam logic [7:0] OpSetColumn = 8'h15;
  localparam logic [7:0] OpSetRow    = 8'h75;
  localparam logic [7:0] OpLine      = 8'h21;
  localparam logic [7:0] OpRect      = 8'h22;
  localparam logic [7:0] OpCopy      = 8'h23;
  localparam logic [7:0] OpDim       = 8'h24;
  localparam logic [7:0] OpClear     = 8'h25;
  localparam logic [7:0] OpFill      = 8'h26;
  localparam logic [7:0] OpRemap     = 8'hA0;
  localparam logic [7:0] OpNormal    = 8'hA4;
  localparam logic [7:0] OpAllOn     = 8'hA5;
  localparam logic [7:0] OpAllOff    = 8'hA6;
  localparam logic [7:0] OpInvert    = 8'hA7;
  localparam logic [7:0] OpOff       = 8'hAE;
  localparam logic [7:0] OpOn        = 8'hAF;

  localparam logic [0:0] CfgSwapRb    = 1'b0;
  localparam logic [0:0] CfgInvertDef = 1'b1;

  // Parameter bytes that follow an opcode.
  function automatic logic [3:0] params_for(logic [7:0] op);
    logic [3:0] n;
    case (op)
      OpSetColumn, OpSetRow: n = 4'd2;
      OpLine:                n = 4'd7;
      OpRect:                n = 4'd10;
      OpCopy:                n = 4'd6;
      OpDim, OpClear:        n = 4'd4;
      OpFill, OpRemap, 8'hA1, 8'hA2, 8'hA8, 8'hAD, 8'hB0, 8'hB1, 8'hB3,
      8'h81, 8'h82, 8'h83, 8'h87, 8'h8A, 8'h8B, 8'h8C, 8'hBE: n = 4'd1;
      default:               n = 4'd0;
    endcase
    return n;
  endfunction

  // Halve each RGB565 channel.
  function automatic logic [15:0] dim565(logic [15:0] p);
    return {1'b0, p[15:12], 1'b0, p[10:6], 1'b0, p[4:1]};
  endfunction

endpackage

// ===== src/odce_ram.sv =====
// Generic single-port RAM with registered read.
module odce_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 6144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/oled_draw_command_engine.sv =====
// OLED command decoder with Bresenham line, rectangle, fill, dim and copy engine.
//
//  channel  signals                                          dir  transfer when
//  input    start_i, operation_i, cmd_byte_i, read_address_i  in   start_i && !busy_o
//  result   done_o, pixel_o, asleep_o, display_enabled_o,     out  done_o (one cycle)
//           inverted_now_o, wide_format_o, params_pending_o
//  config   cfg_we_i, cfg_index_i, cfg_wdata_i                in   cfg_we_i
//
// After reset the frame store is cleared, one pixel per cycle, with busy_o high.
// A plain command byte passes through StByte, and StExec after its last parameter,
// to StDone; a read passes through StRdWait and StRdOut to StDone. Drawing commands
// share the single frame-store port: dim reads, then writes each pixel, and copy
// reads, then writes each copied pixel and skips the rest; primitives add setup states.
// The receiver cannot stall results.
module oled_draw_command_engine #(
  parameter int unsigned Width  = odce_pkg::DefWidth,
  parameter int unsigned Height = odce_pkg::DefHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        operation_i,
  input  logic [7:0]  cmd_byte_i,
  input  logic [12:0] read_address_i,
  output logic        done_o,
  output logic [15:0] pixel_o,
  output logic        asleep_o,
  output logic        display_enabled_o,
  output logic        inverted_now_o,
  output logic        wide_format_o,
  output logic [3:0]  params_pending_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic        cfg_wdata_i
);
  localparam int unsigned Size = Width * Height;
  localparam int unsigned AW   = $clog2(Size);
  localparam int unsigned CW   = 10; // signed coordinate/error width

  typedef enum logic [4:0] {
    StClr, StIdle, StByte, StRdWait, StRdOut, StExec, StDone,
    StLineSetup, StLine, StAreaRow, StAreaPix, StAreaWr,
    StCopyRd, StCopyWr, StRectNext
  } state_e;

  typedef enum logic [1:0] { AreaFill, AreaDim, AreaCopy } area_e;

  state_e state_q;
  area_e  area_q;
  logic [AW-1:0] clr_q;
  logic [7:0] remap_q, active_q;
  logic [3:0] left_q, count_q;
  logic [7:0] prm_q [odce_pkg::NumParams];
  logic fill_q, sleep_q, on_q, inv_q, wide_q, swap_q, invdef_q;
  logic op_q;
  logic [7:0] byte_q;
  logic [12:0] raddr_q;
  logic [15:0] pix_q;
  logic [2:0] rect_q;      // rectangle phase: optional fill, then the top, bottom, left and right edges
  logic [15:0] color_q;
  // shared walker registers
  logic signed [CW-1:0] x_q, y_q, x1_q, y1_q, xa_q, xb_q, ya_q, yb_q, dx_q, dy_q, err_q;
  logic signed [CW-1:0] xd_q, yd_q;
  logic sx_q, sy_q;

  logic mv;
  logic signed [CW-1:0] lw, lh;
  assign mv = remap_q[0];
  assign lw = mv ? CW'(Height) : CW'(Width);
  assign lh = mv ? CW'(Width) : CW'(Height);

  // logical -> physical index
  function automatic logic [AW-1:0] phys(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                         logic [7:0] rm);
    logic my;
    logic [CW-1:0] col, row;
    logic [2*CW-1:0] idx;
    my = rm[4] ^ rm[0];
    if (!rm[0]) begin
      col = rm[1] ? CW'(Width - 1) - x : x;
      row = my ? CW'(Height - 1) - y : y;
    end else begin
      row = my ? CW'(Height - 1) - x : x;
      col = rm[1] ? CW'(Width - 1) - y : y;
    end
    idx = row * (2*CW)'(Width) + (2*CW)'(col);
    return idx[AW-1:0];
  endfunction

  function automatic logic [15:0] mkcol(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic bgr);
    return bgr ? {b[5:1], g[5:0], r[5:1]} : {r[5:1], g[5:0], b[5:1]};
  endfunction

  logic inb;
  assign inb = (x_q >= 0) && (x_q < lw) && (y_q >= 0) && (y_q < lh);

  // walker has left the window
  logic area_end;
  assign area_end = (y_q > yb_q) || (xa_q > xb_q);

  // RAM port
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0] ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = phys(x_q, y_q, remap_q);
    ram_wdata = color_q;
    case (state_q)
      StClr: begin
        ram_we = 1'b1; ram_addr = clr_q; ram_wdata = 16'h0000;
      end
      StIdle, StRdWait, StRdOut: ram_addr = raddr_q[AW-1:0];
      StLine: ram_we = inb;
      StAreaPix: begin
        ram_we = (area_q == AreaFill) && !area_end;
      end
      StAreaWr: begin
        ram_we = (area_q == AreaDim); ram_wdata = odce_pkg::dim565(ram_rdata);
      end
      StCopyRd: ram_addr = phys(x_q, y_q, remap_q);
      StCopyWr: begin
        ram_we = 1'b1; ram_addr = phys(xd_q, yd_q, remap_q); ram_wdata = ram_rdata;
      end
      default: ram_we = 1'b0;
    endcase
  end

  odce_ram #(.Width(16), .Depth(Size)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  logic signed [CW-1:0] e2;
  logic bgr;
  assign e2  = err_q <<< 1;
  assign bgr = remap_q[2] ^ swap_q;

  function automatic logic signed [CW-1:0] sx8(logic [7:0] v);
    return CW'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      clr_q <= '0;
      remap_q <= '0; active_q <= '0; left_q <= '0; count_q <= '0;
      fill_q <= 1'b0; sleep_q <= 1'b1; on_q <= 1'b0; inv_q <= 1'b0; wide_q <= 1'b0;
      swap_q <= 1'b0; invdef_q <= 1'b0;
      done_o <= 1'b0;
      area_q <= AreaFill; rect_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == odce_pkg::CfgSwapRb) swap_q <= cfg_wdata_i;
        else invdef_q <= cfg_wdata_i;
      end
      case (state_q)
        StClr: begin
          if (clr_q == AW'(Size - 1)) state_q <= StIdle;
          clr_q <= clr_q + 1'b1;
        end
        StIdle: begin
          if (start_i) begin
            op_q <= operation_i; byte_q <= cmd_byte_i; raddr_q <= read_address_i;
            state_q <= operation_i ? StRdWait : StByte;
          end
        end
        StRdWait: state_q <= StRdOut;
        StRdOut: begin
          pix_q <= (raddr_q < 13'(Size)) ? ram_rdata : 16'h0000;
          state_q <= StDone;
        end
        StByte: begin
          pix_q <= '0;
          if (left_q != 0) begin
            if (count_q < 4'(odce_pkg::NumParams)) prm_q[count_q] <= byte_q;
            count_q <= count_q + 1'b1;
            left_q <= left_q - 1'b1;
            state_q <= (left_q == 4'd1) ? StExec : StDone;
          end else begin
            active_q <= byte_q; count_q <= '0;
            left_q <= odce_pkg::params_for(byte_q);
            case (byte_q)
              odce_pkg::OpOff, odce_pkg::OpAllOff: sleep_q <= 1'b1;
              odce_pkg::OpOn, odce_pkg::OpAllOn: begin sleep_q <= 1'b0; on_q <= 1'b1; end
              odce_pkg::OpNormal: inv_q <= invdef_q;
              odce_pkg::OpInvert: inv_q <= !invdef_q;
              default: ;
            endcase
            state_q <= StDone;
          end
        end
        StExec: begin
          state_q <= StDone;
          case (active_q)
            odce_pkg::OpRemap: begin remap_q <= prm_q[0]; wide_q <= |prm_q[0][7:6]; end
            odce_pkg::OpFill: fill_q <= prm_q[0][0];
            odce_pkg::OpLine: begin
              x_q <= sx8(prm_q[0]); y_q <= sx8(prm_q[1]);
              x1_q <= sx8(prm_q[2]); y1_q <= sx8(prm_q[3]);
              color_q <= mkcol(prm_q[4], prm_q[5], prm_q[6], bgr);
              rect_q <= 3'd7; state_q <= StLineSetup;
            end
            odce_pkg::OpRect: begin
              color_q <= mkcol(prm_q[7], prm_q[8], prm_q[9], bgr);
              area_q <= AreaFill; rect_q <= 3'd0;
              xa_q <= sx8(prm_q[0]); xb_q <= sx8(prm_q[2]);
              ya_q <= sx8(prm_q[1]); yb_q <= sx8(prm_q[3]);
              state_q <= fill_q ? StAreaRow : StRectNext;
            end
            odce_pkg::OpClear, odce_pkg::OpDim, odce_pkg::OpCopy: begin
              color_q <= 16'h0000; rect_q <= 3'd7;
              area_q <= (active_q == odce_pkg::OpClear) ? AreaFill :
                        (active_q == odce_pkg::OpDim) ? AreaDim : AreaCopy;
              xa_q <= sx8(prm_q[0]); xb_q <= sx8(prm_q[2]);
              ya_q <= sx8(prm_q[1]); yb_q <= sx8(prm_q[3]);
              state_q <= StAreaRow;
            end
            odce_pkg::OpSetColumn, odce_pkg::OpSetRow: ; // window regs unused outside
            default: ;
          endcase
        end
        StAreaRow: begin
          // sort corners; clip for fill/dim; copy keeps unclipped source
          if (xa_q > xb_q) begin xa_q <= xb_q; xb_q <= xa_q; end
          else if (ya_q > yb_q) begin ya_q <= yb_q; yb_q <= ya_q; end
          else begin
            if (area_q != AreaCopy) begin
              if (xb_q >= lw) xb_q <= lw - CW'(1);
              if (yb_q >= lh) yb_q <= lh - CW'(1);
            end
            x_q <= xa_q; y_q <= ya_q;
            xd_q <= sx8(prm_q[4]); yd_q <= sx8(prm_q[5]);
            state_q <= StAreaPix;
          end
        end
        StAreaPix: begin
          if (area_end) begin
            state_q <= (rect_q == 3'd7) ? StDone : StRectNext;
          end else if (area_q == AreaCopy) begin
            if (x_q < lw && y_q < lh && xd_q < lw && yd_q < lh) state_q <= StCopyRd;
            else state_q <= StAreaWr;
          end else if (area_q == AreaDim) begin
            state_q <= StAreaWr;
          end else begin
            if (x_q == xb_q) begin x_q <= xa_q; y_q <= y_q + CW'(1); end
            else x_q <= x_q + CW'(1);
          end
        end
        StCopyRd: state_q <= StCopyWr;
        StCopyWr, StAreaWr: begin
          // copy path also passes through here with no write when skipped
          if (x_q == xb_q) begin
            x_q <= xa_q; y_q <= y_q + CW'(1);
            xd_q <= sx8(prm_q[4]); yd_q <= yd_q + CW'(1);
          end else begin
            x_q <= x_q + CW'(1); xd_q <= xd_q + CW'(1);
          end
          state_q <= StAreaPix;
        end
        StRectNext: begin
          color_q <= mkcol(prm_q[4], prm_q[5], prm_q[6], bgr);
          rect_q <= rect_q + 1'b1;
          case (rect_q)
            3'd0: begin x_q <= sx8(prm_q[0]); y_q <= sx8(prm_q[1]);
                        x1_q <= sx8(prm_q[2]); y1_q <= sx8(prm_q[1]); end
            3'd1: begin x_q <= sx8(prm_q[0]); y_q <= sx8(prm_q[3]);
                        x1_q <= sx8(prm_q[2]); y1_q <= sx8(prm_q[3]); end
            3'd2: begin x_q <= sx8(prm_q[0]); y_q <= sx8(prm_q[1]);
                        x1_q <= sx8(prm_q[0]); y1_q <= sx8(prm_q[3]); end
            default: begin x_q <= sx8(prm_q[2]); y_q <= sx8(prm_q[1]);
                        x1_q <= sx8(prm_q[2]); y1_q <= sx8(prm_q[3]); end
          endcase
          state_q <= StLineSetup;
        end
        StLineSetup: begin
          dx_q <= (x1_q > x_q) ? x1_q - x_q : x_q - x1_q;
          dy_q <= (y1_q > y_q) ? y1_q - y_q : y_q - y1_q;
          err_q <= ((x1_q > x_q) ? x1_q - x_q : x_q - x1_q)
                 - ((y1_q > y_q) ? y1_q - y_q : y_q - y1_q);
          sx_q <= x_q < x1_q; sy_q <= y_q < y1_q;
          state_q <= StLine;
        end
        StLine: begin
          if (x_q == x1_q && y_q == y1_q) begin
            state_q <= (rect_q >= 3'd4) ? StDone : StRectNext;
          end else begin
            if (e2 > -dy_q && e2 < dx_q) err_q <= err_q - dy_q + dx_q;
            else if (e2 > -dy_q) err_q <= err_q - dy_q;
            else if (e2 < dx_q) err_q <= err_q + dx_q;
            if (e2 > -dy_q) x_q <= sx_q ? x_q + CW'(1) : x_q - CW'(1);
            if (e2 < dx_q) y_q <= sy_q ? y_q + CW'(1) : y_q - CW'(1);
          end
        end
        StDone: begin
          done_o <= 1'b1;
          if (!op_q) pix_q <= '0;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o            = (state_q != StIdle);
  assign pixel_o           = pix_q;
  assign asleep_o          = sleep_q;
  assign display_enabled_o = on_q;
  assign inverted_now_o    = inv_q;
  assign wide_format_o     = wide_q;
  assign params_pending_o  = left_q;

`ifndef NO_ASSERTIONS
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == StIdle) else $error("result outside idle");
  a_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= 4'd10) else $error("pending count out of range");
  a_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !op_q) |-> pix_q == 16'h0000) else $error("command returned pixel");
`endif
endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the OLED draw-command engine: command streams, drawing and pixel reads.
`timescale 1ns / 100ps

module testbench;

  localparam int W = 96;
  localparam int H = 64;
  localparam int STORE = W * H;
  localparam int STALL_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1150;
  localparam logic [7:0] OneByteSettings [15] = '{8'hA1, 8'hA2, 8'hA8, 8'hAD, 8'hB0,
      8'hB1, 8'hB3, 8'h81, 8'h82, 8'h83, 8'h87, 8'h8A, 8'h8B, 8'h8C, 8'hBE};
  localparam logic [7:0] UnknownOp = 8'h00;

  typedef struct packed {
    logic [15:0] pixel;
    logic        asleep;
    logic        enabled;
    logic        inverted;
    logic        wide;
    logic [3:0]  pending;
  } status_t;

  logic clk_i, rst_ni;
  logic start_i, busy_o, operation_i;
  logic [7:0] cmd_byte_i;
  logic [12:0] read_address_i;
  logic done_o;
  logic [15:0] pixel_o;
  logic asleep_o, display_enabled_o, inverted_now_o, wide_format_o;
  logic [3:0] params_pending_o;
  logic cfg_we_i, cfg_index_i, cfg_wdata_i;

  oled_draw_command_engine u_top (.*);

  // Panel model state
  logic [15:0] panel_mem [0:STORE-1];
  logic [7:0]  remap_q, col_s, col_e, row_s, row_e, cur_cmd;
  logic [7:0]  arg_buf [0:9];
  int          args_left, args_got;
  bit          fill_q, sleep_q, on_q, inv_q, wide_q, swap_rb_q, inv_def_q;

  status_t expected_status_q [$];
  int errors, items_sent, results_seen, reads_sent, idle_pct;
  int stall_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int log_w();
    return remap_q[0] ? H : W;
  endfunction

  function automatic int log_h();
    return remap_q[0] ? W : H;
  endfunction

  function automatic int panel_index(int x, int y);
    bit mv, mx, my;
    int col, row;
    mv = remap_q[0];
    mx = remap_q[1];
    my = remap_q[4] ^ mv;
    if (!mv) begin
      col = mx ? (W - 1 - x) : x;
      row = my ? (H - 1 - y) : y;
    end else begin
      row = my ? (H - 1 - x) : x;
      col = mx ? (W - 1 - y) : y;
    end
    return (row * W + col) % STORE;
  endfunction

  function automatic void plot(int x, int y, logic [15:0] c);
    if (x < 0 || x >= log_w() || y < 0 || y >= log_h()) return;
    panel_mem[panel_index(x, y)] = c;
  endfunction

  function automatic logic [15:0] pack565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [4:0] r5, b5;
    logic [5:0] g6;
    r5 = r[5:1];
    g6 = g[5:0];
    b5 = b[5:1];
    if (remap_q[2] ^ swap_rb_q) return {b5, g6, r5};
    return {r5, g6, b5};
  endfunction

  function automatic void bresenham(int x0, int y0, int x1, int y1, logic [15:0] c);
    int dx, dy, sx, sy, err, e2;
    dx = x1 > x0 ? x1 - x0 : x0 - x1;
    dy = y1 > y0 ? y1 - y0 : y0 - y1;
    sx = x0 < x1 ? 1 : -1;
    sy = y0 < y1 ? 1 : -1;
    err = dx - dy;
    forever begin
      plot(x0, y0, c);
      if (x0 == x1 && y0 == y1) break;
      e2 = err * 2;
      if (e2 > -dy) begin err -= dy; x0 += sx; end
      if (e2 < dx) begin err += dx; y0 += sy; end
    end
  endfunction

  // Fill or halve a sorted, clipped window
  function automatic void area_fill(int x0, int y0, int x1, int y1, bit dim, logic [15:0] c);
    int t, i;
    logic [15:0] p;
    if (x0 > x1) begin t = x0; x0 = x1; x1 = t; end
    if (y0 > y1) begin t = y0; y0 = y1; y1 = t; end
    if (x1 >= log_w()) x1 = log_w() - 1;
    if (y1 >= log_h()) y1 = log_h() - 1;
    for (int y = y0; y <= y1; y++)
      for (int x = x0; x <= x1; x++) begin
        i = panel_index(x, y);
        p = panel_mem[i];
        panel_mem[i] = dim ? {1'b0, p[15:12], 1'b0, p[10:6], 1'b0, p[4:1]} : c;
      end
  endfunction

  function automatic void area_copy(int x0, int y0, int x1, int y1, int xd, int yd);
    int t, ys, yt, xs, xt;
    if (x0 > x1) begin t = x0; x0 = x1; x1 = t; end
    if (y0 > y1) begin t = y0; y0 = y1; y1 = t; end
    for (int r = 0; r <= y1 - y0; r++) begin
      ys = y0 + r;
      yt = yd + r;
      if (ys < log_h() && yt < log_h())
        for (int c = 0; c <= x1 - x0; c++) begin
          xs = x0 + c;
          xt = xd + c;
          if (xs < log_w() && xt < log_w())
            panel_mem[panel_index(xt, yt)] = panel_mem[panel_index(xs, ys)];
        end
    end
  endfunction

  function automatic void clamp_win(input int a, input int b, input int maxv,
                                    output logic [7:0] s, output logic [7:0] e);
    int sv, ev;
    sv = a > maxv ? maxv : a;
    ev = b > maxv ? maxv : b;
    if (ev < sv) ev = sv;
    s = sv[7:0];
    e = ev[7:0];
  endfunction

  function automatic void run_command();
    logic [15:0] border;
    case (cur_cmd)
      odce_pkg::OpSetColumn:
        if (!remap_q[0]) clamp_win(arg_buf[0], arg_buf[1], W - 1, col_s, col_e);
        else clamp_win(arg_buf[0], arg_buf[1], H - 1, row_s, row_e);
      odce_pkg::OpSetRow:
        if (!remap_q[0]) clamp_win(arg_buf[0], arg_buf[1], H - 1, row_s, row_e);
        else clamp_win(arg_buf[0], arg_buf[1], W - 1, col_s, col_e);
      odce_pkg::OpRemap: begin
        remap_q = arg_buf[0];
        wide_q = remap_q[7:6] != 2'b00;
      end
      odce_pkg::OpFill: fill_q = arg_buf[0][0];
      odce_pkg::OpLine: bresenham(arg_buf[0], arg_buf[1], arg_buf[2], arg_buf[3],
                                  pack565(arg_buf[4], arg_buf[5], arg_buf[6]));
      odce_pkg::OpRect: begin
        border = pack565(arg_buf[4], arg_buf[5], arg_buf[6]);
        if (fill_q) area_fill(arg_buf[0], arg_buf[1], arg_buf[2], arg_buf[3], 1'b0,
                              pack565(arg_buf[7], arg_buf[8], arg_buf[9]));
        bresenham(arg_buf[0], arg_buf[1], arg_buf[2], arg_buf[1], border);
        bresenham(arg_buf[0], arg_buf[3], arg_buf[2], arg_buf[3], border);
        bresenham(arg_buf[0], arg_buf[1], arg_buf[0], arg_buf[3], border);
        bresenham(arg_buf[2], arg_buf[1], arg_buf[2], arg_buf[3], border);
      end
      odce_pkg::OpCopy: area_copy(arg_buf[0], arg_buf[1], arg_buf[2], arg_buf[3],
                                  arg_buf[4], arg_buf[5]);
      odce_pkg::OpDim: area_fill(arg_buf[0], arg_buf[1], arg_buf[2], arg_buf[3], 1'b1,
                                 16'h0000);
      odce_pkg::OpClear: area_fill(arg_buf[0], arg_buf[1], arg_buf[2], arg_buf[3], 1'b0,
                                   16'h0000);
      default: ;
    endcase
  endfunction

  function automatic int arg_count(logic [7:0] op);
    case (op)
      odce_pkg::OpSetColumn, odce_pkg::OpSetRow: return 2;
      odce_pkg::OpLine: return 7;
      odce_pkg::OpRect: return 10;
      odce_pkg::OpCopy: return 6;
      odce_pkg::OpDim, odce_pkg::OpClear: return 4;
      odce_pkg::OpFill, odce_pkg::OpRemap: return 1;
      default: begin
        foreach (OneByteSettings[k]) if (OneByteSettings[k] == op) return 1;
        return 0;
      end
    endcase
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    if (args_left > 0) begin
      if (args_got < 10) arg_buf[args_got] = b;
      args_got++;
      args_left--;
      if (args_left == 0) run_command();
      return;
    end
    cur_cmd = b;
    args_got = 0;
    args_left = arg_count(b);
    case (b)
      odce_pkg::OpOff, odce_pkg::OpAllOff: sleep_q = 1'b1;
      odce_pkg::OpOn, odce_pkg::OpAllOn: begin sleep_q = 1'b0; on_q = 1'b1; end
      odce_pkg::OpNormal: inv_q = inv_def_q;
      odce_pkg::OpInvert: inv_q = !inv_def_q;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Check every result against the oldest prediction
  always @(posedge clk_i) begin
    status_t e;
    if (rst_ni && done_o) begin
      results_seen++;
      if (expected_status_q.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        e = expected_status_q.pop_front();
        if (pixel_o !== e.pixel) report_mismatch("pixel", pixel_o, e.pixel);
        if (asleep_o !== e.asleep) report_mismatch("asleep", asleep_o, e.asleep);
        if (display_enabled_o !== e.enabled)
          report_mismatch("display_enabled", display_enabled_o, e.enabled);
        if (inverted_now_o !== e.inverted)
          report_mismatch("inverted_now", inverted_now_o, e.inverted);
        if (wide_format_o !== e.wide) report_mismatch("wide_format", wide_format_o, e.wide);
        if (params_pending_o !== e.pending)
          report_mismatch("params_pending", params_pending_o, e.pending);
      end
    end
  end

  // Stop the run when nothing transfers for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", stall_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(bit op, logic [7:0] b, logic [12:0] addr);
    status_t s;
    start_i <= 1'b1;
    operation_i <= op;
    cmd_byte_i <= b;
    read_address_i <= addr;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    s.pixel = 16'h0000;
    if (op) begin
      reads_sent++;
      if (addr < STORE) s.pixel = panel_mem[addr];
    end else decode_byte(b);
    s.asleep = sleep_q;
    s.enabled = on_q;
    s.inverted = inv_q;
    s.wide = wide_q;
    s.pending = args_left[3:0];
    expected_status_q.push_back(s);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(9) == 0 ? $urandom_range(7, 30) : $urandom_range(1, 6))
        @(posedge clk_i);
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(1'b0, b, 13'($urandom_range(8191)));
  endtask

  task automatic read_pixel(int addr);
    send_item(1'b1, 8'($urandom_range(255)), addr[12:0]);
  endtask

  // Opcode with its argument bytes; reads may slip in between the bytes
  task automatic send_command(logic [7:0] op, logic [7:0] args [10], bit mix_reads);
    int n;
    n = arg_count(op);
    send_byte(op);
    for (int k = 0; k < n; k++) begin
      if (mix_reads && $urandom_range(9) == 0) read_pixel($urandom_range(STORE - 1));
      send_byte(args[k]);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == odce_pkg::CfgSwapRb) swap_rb_q = val;
    else inv_def_q = val;
    @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    read_pixel(0);
    read_pixel(STORE - 1);
    read_pixel(STORE);
    read_pixel(8191);
    send_byte(UnknownOp);
    send_byte(8'hFF);
    drain();
  endtask

  task automatic test_display_flags();
    write_cfg(odce_pkg::CfgInvertDef, 1'b1);
    send_byte(odce_pkg::OpOn);
    send_byte(odce_pkg::OpNormal);
    send_byte(odce_pkg::OpInvert);
    send_byte(odce_pkg::OpAllOff);
    send_byte(odce_pkg::OpAllOn);
    send_byte(odce_pkg::OpOff);
    drain();
    write_cfg(odce_pkg::CfgInvertDef, 1'b0);
    send_byte(odce_pkg::OpNormal);
    send_byte(odce_pkg::OpInvert);
    drain();
  endtask

  task automatic test_draw_directed();
    logic [7:0] a [10];
    a = '{8'd0, 8'd0, 8'd95, 8'd63, 8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd0, 8'd0};
    send_command(odce_pkg::OpLine, a, 1'b0);
    read_pixel(0);
    read_pixel(STORE - 1);
    // Parameter-only setting and a read in the middle of collection
    a = '{8'd7, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    send_byte(8'h81);
    read_pixel(0);
    send_byte(a[0]);
    a = '{8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    send_command(odce_pkg::OpFill, a, 1'b0);
    a = '{8'd255, 8'd255, 8'd0, 8'd0, 8'h3E, 8'h00, 8'hC2, 8'hAA, 8'h55, 8'hFE};
    send_command(odce_pkg::OpRect, a, 1'b0);
    read_pixel(W + 1);
    a = '{8'd0, 8'd0, 8'd200, 8'd200, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    send_command(odce_pkg::OpDim, a, 1'b0);
    a = '{8'd0, 8'd0, 8'd40, 8'd30, 8'd5, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0};
    send_command(odce_pkg::OpCopy, a, 1'b0);
    read_pixel(3 * W + 5);
    a = '{8'd10, 8'd10, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    send_command(odce_pkg::OpClear, a, 1'b0);
    drain();
    // Swapped axes with mirrors and both colour-order swaps; window clamping
    write_cfg(odce_pkg::CfgSwapRb, 1'b1);
    a = '{8'hD7, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    send_command(odce_pkg::OpRemap, a, 1'b0);
    a = '{8'd200, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    send_command(odce_pkg::OpSetColumn, a, 1'b0);
    send_command(odce_pkg::OpSetRow, a, 1'b0);
    a = '{8'd2, 8'd90, 8'd60, 8'd1, 8'h12, 8'h34, 8'h56, 8'd0, 8'd0, 8'd0};
    send_command(odce_pkg::OpLine, a, 1'b0);
    read_pixel(STORE - 1);
    drain();
    write_cfg(odce_pkg::CfgSwapRb, 1'b0);
  endtask

  function automatic logic [7:0] near_coord(int c);
    int v;
    v = c + int'($urandom_range(24)) - 12;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic random_sequence();
    logic [7:0] a [10];
    logic [7:0] op;
    int pick, bx, by;
    bit full;
    pick = $urandom_range(99);
    if (pick < 18) begin
      read_pixel($urandom_range(3) == 0 ? $urandom_range(8191) : $urandom_range(STORE - 1));
      return;
    end
    if (pick < 26) begin
      send_byte(8'($urandom_range(255)));
      return;
    end
    case ($urandom_range(15))
      0: op = odce_pkg::OpSetColumn;  1: op = odce_pkg::OpSetRow;
      2, 3: op = odce_pkg::OpLine;  4, 5: op = odce_pkg::OpRect;
      6: op = odce_pkg::OpCopy;  7: op = odce_pkg::OpDim;  8: op = odce_pkg::OpClear;
      9: op = odce_pkg::OpFill;
      10: op = odce_pkg::OpRemap;  11: op = OneByteSettings[$urandom_range(14)];
      12: op = ($urandom_range(1)) ? odce_pkg::OpNormal : odce_pkg::OpInvert;
      13: op = ($urandom_range(1)) ? odce_pkg::OpAllOn : odce_pkg::OpAllOff;
      14: op = ($urandom_range(1)) ? odce_pkg::OpOn : odce_pkg::OpOff;
      default: op = UnknownOp;
    endcase
    foreach (a[k]) a[k] = 8'($urandom_range(255));
    full = $urandom_range(59) == 0;
    bx = $urandom_range(105);
    by = $urandom_range(105);
    if (op == odce_pkg::OpLine || op == odce_pkg::OpRect || op == odce_pkg::OpCopy ||
        op == odce_pkg::OpDim || op == odce_pkg::OpClear) begin
      a[0] = full ? 8'd0 : near_coord(bx);
      a[1] = full ? 8'd0 : near_coord(by);
      a[2] = full ? 8'd255 : near_coord(bx);
      a[3] = full ? 8'd255 : near_coord(by);
      if (op == odce_pkg::OpCopy) begin
        a[4] = 8'($urandom_range(105));
        a[5] = 8'($urandom_range(105));
      end
    end
    send_command(op, a, 1'b1);
  endtask

  task automatic test_random();
    int phase_end;
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 29 : (ph == 1) ? 64 : 0;
      phase_end = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < phase_end) random_sequence();
      // Hold until every prediction has been matched, then retune
      drain();
      write_cfg(odce_pkg::CfgSwapRb, 1'($urandom_range(1)));
      write_cfg(odce_pkg::CfgInvertDef, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    reads_sent = 0;
    idle_pct = 0;
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    operation_i <= 1'b0;
    cmd_byte_i <= 8'h00;
    read_address_i <= 13'h0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= 1'b0;
    cfg_wdata_i <= 1'b0;
    foreach (panel_mem[i]) panel_mem[i] = 16'h0000;
    foreach (arg_buf[i]) arg_buf[i] = 8'h00;
    remap_q = 8'h00;
    col_s = 8'd0;
    col_e = 8'(W - 1);
    row_s = 8'd0;
    row_e = 8'(H - 1);
    cur_cmd = 8'h00;
    args_left = 0;
    args_got = 0;
    fill_q = 0;
    sleep_q = 1;
    on_q = 0;
    inv_q = 0;
    wide_q = 0;
    swap_rb_q = 0;
    inv_def_q = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_cfg(odce_pkg::CfgSwapRb, 1'b0);
    write_cfg(odce_pkg::CfgInvertDef, 1'b0);
    test_reset_state();
    test_display_flags();
    test_draw_directed();
    test_random();
    drain();
    repeat (20) @(posedge clk_i);
    if (expected_status_q.size() != 0)
      report_mismatch("results missing", 0, expected_status_q.size());
    $display("covered %0d items (%0d pixel reads), %0d results checked, %0d mismatches",
             items_sent, reads_sent, results_seen, errors);
    $display("drawing, remap, window, flag commands and both registers at both values");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/odce_pkg.sv
src/odce_ram.sv
src/oled_draw_command_engine.sv
bench/testbench.sv
